/* src/fcmix_pkg.sv */
package fcmix_pkg;

  localparam int unsigned RatioW    = 7;
  localparam int unsigned ModeW     = 4;
  localparam int unsigned PixW      = 8;
  localparam int unsigned ErrW      = 10;
  localparam int unsigned NumW      = 15;
  localparam int unsigned RecipW    = 13;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned NumChan   = 3;

  localparam logic [RatioW-1:0] RatioMax  = 7'd100;
  localparam logic [RatioW-1:0] RatioHalf = 7'd50;
  localparam logic [RatioW-1:0] WeightOne = 7'd100;
  localparam logic [PixW-1:0]   FullByte  = 8'd255;
  // floor(x/100) == (x*5243) >> 19 for x up to 25500
  localparam logic [RecipW-1:0] RecipMul  = 13'd5243;

  localparam logic signed [ErrW-1:0] DitherLimit = 10'sd127;
  localparam logic signed [ErrW-1:0] DitherStep  = 10'sd256;

  typedef enum logic [ModeW-1:0] {
    ModeRg1     = 4'd0,
    ModeRg2     = 4'd1,
    ModeRb1     = 4'd2,
    ModeRb2     = 4'd3,
    ModeGb1     = 4'd4,
    ModeGb2     = 4'd5,
    ModeRnr     = 4'd6,
    ModeGng     = 4'd7,
    ModeBnb     = 4'd8,
    ModeDither1 = 4'd9,
    ModeDither2 = 4'd10,
    ModeBlink   = 4'd11
  } mode_e;

  typedef enum logic {
    RegRatio = 1'b0,
    RegMode  = 1'b1
  } reg_idx_e;

  // one channel's numerator: wx*x + wy*y
  typedef struct packed {
    logic [RatioW-1:0] wx;
    logic [PixW-1:0]   x;
    logic [RatioW-1:0] wy;
    logic [PixW-1:0]   y;
  } chan_ops_t;

  typedef struct packed {
    logic num_en;
    logic out_en;
  } stage_en_t;

  function automatic chan_ops_t op_blend(logic [RatioW-1:0] w, logic [PixW-1:0] x,
                                         logic [PixW-1:0] y);
    chan_ops_t o;
    o.wx = w;
    o.x  = x;
    o.wy = WeightOne - w;
    o.y  = y;
    return o;
  endfunction

  function automatic chan_ops_t op_scale(logic [RatioW-1:0] w, logic [PixW-1:0] x);
    chan_ops_t o;
    o.wx = w;
    o.x  = x;
    o.wy = '0;
    o.y  = '0;
    return o;
  endfunction

endpackage

/* src/fcmix_front.sv */
module fcmix_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        frame_start_i,
  input  logic [7:0]                  first_low_i,
  input  logic [7:0]                  first_mid_i,
  input  logic [7:0]                  first_high_i,
  input  logic [7:0]                  second_low_i,
  input  logic [7:0]                  second_mid_i,
  input  logic [7:0]                  second_high_i,
  input  logic [fcmix_pkg::RatioW-1:0] ratio_i,
  input  logic [fcmix_pkg::ModeW-1:0]  mode_i,
  output fcmix_pkg::chan_ops_t        ops_o [fcmix_pkg::NumChan]
);
  import fcmix_pkg::*;

  logic [RatioW-1:0]      r, wc, wa, wb;
  logic [RatioW:0]        wb_wide;
  logic [PixW-1:0]        drive, inv_f3, inv_s2;
  logic signed [ErrW-1:0] err_q, err_d, err_base, err_sum;
  logic                   tint;
  mode_e                  mode;
  chan_ops_t              op_a, op_b, zero_op;

  always_comb begin
    r       = (ratio_i > RatioMax) ? RatioMax : ratio_i;
    wc      = r;
    wb_wide = 8'd200 - {r, 1'b0};
    wa      = (r > RatioHalf) ? WeightOne : {r[RatioW-2:0], 1'b0};
    wb      = (r > RatioHalf) ? wb_wide[RatioW-1:0] : WeightOne;
  end

  always_comb begin
    mode     = mode_e'(mode_i);
    err_base = frame_start_i ? '0 : err_q;
    drive    = (mode == ModeDither2) ? second_high_i : first_high_i;
    err_sum  = err_base + $signed({2'b00, FullByte - drive});
    tint     = err_sum > DitherLimit;
    err_d    = err_base;
    if (mode == ModeDither1 || mode == ModeDither2) begin
      err_d = tint ? (err_sum - DitherStep) : err_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
    end else if (accept_i) begin
      err_q <= err_d;
    end
  end

  always_comb begin
    inv_f3  = FullByte - first_high_i;
    inv_s2  = FullByte - second_mid_i;
    op_a    = op_scale(wa, inv_f3);
    op_b    = op_scale(wb, inv_s2);
    zero_op = op_scale('0, '0);
    ops_o[0] = zero_op;
    ops_o[1] = zero_op;
    ops_o[2] = zero_op;
    case (mode)
      ModeRg1: begin
        ops_o[2] = op_blend(wc, FullByte, second_mid_i);
        ops_o[1] = op_blend(wc, first_high_i, FullByte);
        ops_o[0] = op_blend(wc, first_high_i, second_mid_i);
      end
      ModeRg2: begin
        ops_o[2] = op_a;
        ops_o[1] = op_b;
      end
      ModeRb1: begin
        ops_o[2] = op_blend(wc, FullByte, second_mid_i);
        ops_o[0] = op_blend(wc, first_high_i, FullByte);
        ops_o[1] = op_blend(wc, first_high_i, second_mid_i);
      end
      ModeRb2: begin
        ops_o[2] = op_a;
        ops_o[0] = op_b;
      end
      ModeGb1: begin
        ops_o[1] = op_blend(wc, FullByte, second_mid_i);
        ops_o[0] = op_blend(wc, first_high_i, FullByte);
        ops_o[2] = op_blend(wc, first_high_i, second_mid_i);
      end
      ModeGb2: begin
        ops_o[1] = op_a;
        ops_o[0] = op_b;
      end
      ModeRnr: begin
        ops_o[2] = op_a;
        ops_o[1] = op_b;
        ops_o[0] = op_b;
      end
      ModeGng: begin
        ops_o[1] = op_a;
        ops_o[0] = op_b;
        ops_o[2] = op_b;
      end
      ModeBnb: begin
        ops_o[0] = op_a;
        ops_o[2] = op_b;
        ops_o[1] = op_b;
      end
      ModeDither1: begin
        if (tint) begin
          ops_o[2] = op_blend(wa, FullByte, second_high_i);
          ops_o[1] = op_scale(WeightOne - wa, second_mid_i);
          ops_o[0] = op_scale(WeightOne - wa, second_low_i);
        end else begin
          ops_o[2] = op_scale(wb, second_high_i);
          ops_o[1] = op_scale(wb, second_mid_i);
          ops_o[0] = op_scale(wb, second_low_i);
        end
      end
      ModeDither2: begin
        if (tint) begin
          ops_o[2] = op_blend(wb, FullByte, first_high_i);
          ops_o[1] = op_scale(WeightOne - wb, first_mid_i);
          ops_o[0] = op_scale(WeightOne - wb, first_low_i);
        end else begin
          ops_o[2] = op_scale(wa, first_high_i);
          ops_o[1] = op_scale(wa, first_mid_i);
          ops_o[0] = op_scale(wa, first_low_i);
        end
      end
      default: begin
        ops_o[0] = zero_op;
      end
    endcase
  end

endmodule

/* src/fcmix_chan.sv */
module fcmix_chan (
  input  logic                 clk_i,
  input  fcmix_pkg::chan_ops_t ops_i,
  input  fcmix_pkg::stage_en_t en_i,
  output logic [7:0]           pix_o
);
  import fcmix_pkg::*;

  logic [2*PixW-1:0]     num_wide;
  logic [NumW-1:0]       num_q;
  logic [NumW+RecipW-1:0] prod;
  logic [PixW-1:0]       pix_q;

  // numerator is at most 100*255, fits NumW
  assign num_wide = (2*PixW)'(ops_i.wx * ops_i.x) + (2*PixW)'(ops_i.wy * ops_i.y);
  assign prod     = (NumW+RecipW)'(num_q) * (NumW+RecipW)'(RecipMul);

  always_ff @(posedge clk_i) begin
    if (en_i.num_en) begin
      num_q <= num_wide[NumW-1:0];
    end
    if (en_i.out_en) begin
      pix_q <= prod[RecipShift +: PixW];
    end
  end

  assign pix_o = pix_q;

endmodule

/* src/two_image_false_colour_overlay_mixer.sv */
// Two-image false-colour overlay mixer.
// Input channel (in_valid_i / in_ready_o): one beat carries a pixel pair, three
// bytes from each image, plus frame_start which clears the dither error first.
// Output channel (out_valid_o / out_ready_i): one beat carries the mixed pixel.
// Mode and mix ratio are set over the APB port: mix_ratio at 0x0, mix_mode at
// 0x4; pready is tied high and reads return the register value.
// An input beat passes three registered stages to output valid: operand select and
// dither update, then the weighted sum (two 7x8 products), then the divide by
// 100 done as a 15x13 multiply by a reciprocal. One beat per cycle sustained while out_ready_i is high.
// The dither error register is updated at the input handshake, so consecutive
// pixels chain through it with no gap.
// Each stage holds its data while the next is full and stalled; a stalled receiver fills
// the three stages before in_ready_o drops.
// Reset clears all stage valids and the dither error, sets mix_ratio to 50 and
// mix_mode to rg1.
module two_image_false_colour_overlay_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  first_low_i,
  input  logic [7:0]  first_mid_i,
  input  logic [7:0]  first_high_i,
  input  logic [7:0]  second_low_i,
  input  logic [7:0]  second_mid_i,
  input  logic [7:0]  second_high_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_low_o,
  output logic [7:0]  out_mid_o,
  output logic [7:0]  out_high_o
);
  import fcmix_pkg::*;

  logic [RatioW-1:0] ratio_q;
  logic [ModeW-1:0]  mode_q;
  logic              wr_en;
  reg_idx_e          reg_idx;

  logic      v1_q, v2_q, v3_q;
  logic      rdy1, rdy2, rdy3;
  logic      in_acc;
  stage_en_t stage_en;
  chan_ops_t ops_d [NumChan];
  chan_ops_t ops_q [NumChan];
  logic [PixW-1:0] pix [NumChan];

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= 7'd50;
      mode_q  <= ModeRg1;
    end else if (wr_en) begin
      case (reg_idx)
        RegRatio: ratio_q <= pwdata[RatioW-1:0];
        RegMode:  mode_q  <= pwdata[ModeW-1:0];
        default:  ratio_q <= ratio_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegRatio: prdata = {{(32-RatioW){1'b0}}, ratio_q};
      RegMode:  prdata = {{(32-ModeW){1'b0}}, mode_q};
      default:  prdata = '0;
    endcase
  end

  assign rdy3       = ~v3_q | out_ready_i;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;
  assign in_acc     = in_valid_i & rdy1;

  assign stage_en.num_en = v1_q & rdy2;
  assign stage_en.out_en = v2_q & rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  fcmix_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .frame_start_i (frame_start_i),
    .first_low_i   (first_low_i),
    .first_mid_i   (first_mid_i),
    .first_high_i  (first_high_i),
    .second_low_i  (second_low_i),
    .second_mid_i  (second_mid_i),
    .second_high_i (second_high_i),
    .ratio_i       (ratio_q),
    .mode_i        (mode_q),
    .ops_o         (ops_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ops_q <= ops_d;
    end
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    fcmix_chan u_chan (
      .clk_i (clk_i),
      .ops_i (ops_q[c]),
      .en_i  (stage_en),
      .pix_o (pix[c])
    );
  end

  assign out_valid_o = v3_q;
  assign out_low_o   = pix[0];
  assign out_mid_o   = pix[1];
  assign out_high_o  = pix[2];

endmodule

/* verif/two_image_false_colour_overlay_mixer_tb.sv */
`timescale 1ns / 1ps

module two_image_false_colour_overlay_mixer_tb;
  import fcmix_pkg::*;

  localparam int PipeDepth  = 3;
  localparam int DrainCycles = 20;
  localparam int StallLimit = 4000;
  localparam int Segments   = 8;
  localparam int SegBeats   = 65;

  typedef struct packed {
    logic [PixW-1:0] f_lo;
    logic [PixW-1:0] f_mid;
    logic [PixW-1:0] f_hi;
    logic [PixW-1:0] s_lo;
    logic [PixW-1:0] s_mid;
    logic [PixW-1:0] s_hi;
    logic            frame_start;
  } pix_pair_t;

  typedef struct packed {
    logic [PixW-1:0] lo;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] hi;
  } mixed_pix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  first_low_i = '0;
  logic [7:0]  first_mid_i = '0;
  logic [7:0]  first_high_i = '0;
  logic [7:0]  second_low_i = '0;
  logic [7:0]  second_mid_i = '0;
  logic [7:0]  second_high_i = '0;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_low_o;
  logic [7:0]  out_mid_o;
  logic [7:0]  out_high_o;

  two_image_false_colour_overlay_mixer i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_o,
    .first_low_i,
    .first_mid_i,
    .first_high_i,
    .second_low_i,
    .second_mid_i,
    .second_high_i,
    .frame_start_i,
    .out_valid_o,
    .out_ready_i,
    .out_low_o,
    .out_mid_o,
    .out_high_o
  );

  // predictor state
  logic [RatioW-1:0] cfg_ratio = RatioHalf;
  logic [ModeW-1:0]  cfg_mode = ModeRg1;
  int                dither_acc = 0;

  mixed_pix_t pending_mixes[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int n_errors = 0;
  int n_pixels = 0;
  int n_writes = 0;
  int n_tinted = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pct_scale(int unsigned w, int unsigned x);
    return (w * x) / 100;
  endfunction

  function automatic int unsigned pct_blend(int unsigned w, int unsigned x, int unsigned y);
    return (w * x + (100 - w) * y) / 100;
  endfunction

  function automatic mixed_pix_t mix_pixel(pix_pair_t p);
    int unsigned r, wa, wb, wc, one_w, full;
    int unsigned o1, o2, o3;
    one_w = WeightOne;
    full  = FullByte;
    r  = (cfg_ratio > RatioMax) ? RatioMax : cfg_ratio;
    wc = r;
    wa = (r > RatioHalf) ? one_w : 2 * r;
    wb = (r > RatioHalf) ? 2 * one_w - 2 * r : one_w;
    o1 = 0;
    o2 = 0;
    o3 = 0;
    if (p.frame_start) dither_acc = 0;
    case (cfg_mode)
      ModeRg1: begin
        o3 = pct_blend(wc, full, p.s_mid);
        o2 = pct_blend(wc, p.f_hi, full);
        o1 = pct_blend(wc, p.f_hi, p.s_mid);
      end
      ModeRg2: begin
        o3 = pct_scale(wa, full - p.f_hi);
        o2 = pct_scale(wb, full - p.s_mid);
      end
      ModeRb1: begin
        o3 = pct_blend(wc, full, p.s_mid);
        o1 = pct_blend(wc, p.f_hi, full);
        o2 = pct_blend(wc, p.f_hi, p.s_mid);
      end
      ModeRb2: begin
        o3 = pct_scale(wa, full - p.f_hi);
        o1 = pct_scale(wb, full - p.s_mid);
      end
      ModeGb1: begin
        o2 = pct_blend(wc, full, p.s_mid);
        o1 = pct_blend(wc, p.f_hi, full);
        o3 = pct_blend(wc, p.f_hi, p.s_mid);
      end
      ModeGb2: begin
        o2 = pct_scale(wa, full - p.f_hi);
        o1 = pct_scale(wb, full - p.s_mid);
      end
      ModeRnr: begin
        o3 = pct_scale(wa, full - p.f_hi);
        o2 = pct_scale(wb, full - p.s_mid);
        o1 = o2;
      end
      ModeGng: begin
        o2 = pct_scale(wa, full - p.f_hi);
        o1 = pct_scale(wb, full - p.s_mid);
        o3 = o1;
      end
      ModeBnb: begin
        o1 = pct_scale(wa, full - p.f_hi);
        o3 = pct_scale(wb, full - p.s_mid);
        o2 = o3;
      end
      ModeDither1: begin
        dither_acc += int'(full) - int'(p.f_hi);
        if (dither_acc > int'(DitherLimit)) begin
          o3 = pct_blend(wa, full, p.s_hi);
          o2 = pct_scale(one_w - wa, p.s_mid);
          o1 = pct_scale(one_w - wa, p.s_lo);
          dither_acc -= int'(DitherStep);
          n_tinted++;
        end else begin
          o3 = pct_scale(wb, p.s_hi);
          o2 = pct_scale(wb, p.s_mid);
          o1 = pct_scale(wb, p.s_lo);
        end
      end
      ModeDither2: begin
        dither_acc += int'(full) - int'(p.s_hi);
        if (dither_acc > int'(DitherLimit)) begin
          o3 = pct_blend(wb, full, p.f_hi);
          o2 = pct_scale(one_w - wb, p.f_mid);
          o1 = pct_scale(one_w - wb, p.f_lo);
          dither_acc -= int'(DitherStep);
          n_tinted++;
        end else begin
          o3 = pct_scale(wa, p.f_hi);
          o2 = pct_scale(wa, p.f_mid);
          o1 = pct_scale(wa, p.f_lo);
        end
      end
      default: begin
      end
    endcase
    return '{lo: o1[PixW-1:0], mid: o2[PixW-1:0], hi: o3[PixW-1:0]};
  endfunction

  // output side: random stalls and beat check
  always @(posedge clk_i) begin : result_check
    mixed_pix_t want;
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_mixes.size() == 0) begin
        $error("output beat with nothing expected: %h %h %h",
               out_low_o, out_mid_o, out_high_o);
        n_errors++;
      end else begin
        want = pending_mixes.pop_front();
        if (out_low_o !== want.lo) begin
          $error("out_low expected %0d got %0d", want.lo, out_low_o);
          n_errors++;
        end
        if (out_mid_o !== want.mid) begin
          $error("out_mid expected %0d got %0d", want.mid, out_mid_o);
          n_errors++;
        end
        if (out_high_o !== want.hi) begin
          $error("out_high expected %0d got %0d", want.hi, out_high_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("stalled for %0d cycles with %0d beats outstanding",
                 idle_cycles, pending_mixes.size());
        $display("two_image_false_colour_overlay_mixer_tb failed");
        $finish;
      end
    end
  end

  task automatic send_pixel(pix_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    first_low_i   <= p.f_lo;
    first_mid_i   <= p.f_mid;
    first_high_i  <= p.f_hi;
    second_low_i  <= p.s_lo;
    second_mid_i  <= p.s_mid;
    second_high_i <= p.s_hi;
    frame_start_i <= p.frame_start;
    do @(posedge clk_i); while (!in_ready_o);
    pending_mixes.push_back(mix_pixel(p));
    n_pixels++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_mixes.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegRatio: cfg_ratio = value[RatioW-1:0];
      RegMode:  cfg_mode  = value[ModeW-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  function automatic pix_pair_t random_pair();
    pix_pair_t p;
    logic [63:0] rnd;
    rnd = {$urandom(), $urandom()};
    p = rnd[$bits(pix_pair_t)-1:0];
    p.frame_start = ($urandom_range(31) == 0);
    return p;
  endfunction

  task automatic test_reset_defaults();
    pix_pair_t p;
    p = '0;
    send_pixel(p);
    p = '1;
    send_pixel(p);
  endtask

  // every mode code, ratio beyond range so it saturates
  task automatic test_mode_sweep();
    pix_pair_t p;
    logic [ModeW-1:0] m;
    write_reg(RegRatio, 32'({RatioW{1'b1}}));
    for (int i = 0; i < 2**ModeW; i++) begin
      m = i[ModeW-1:0];
      write_reg(RegMode, 32'(m));
      p.f_lo  = {PixW{m[0]}};
      p.f_mid = ~p.f_lo;
      p.f_hi  = {PixW{m[1]}};
      p.s_lo  = {PixW{m[2]}};
      p.s_mid = ~p.s_lo;
      p.s_hi  = ~p.f_hi;
      p.frame_start = m[3];
      send_pixel(p);
    end
  endtask

  task automatic test_ratio_marks();
    logic [RatioW-1:0] marks[5];
    pix_pair_t p;
    marks = '{'0, 7'd1, RatioHalf, RatioHalf + 7'd1, RatioMax};
    write_reg(RegMode, 32'(ModeRg2));
    foreach (marks[i]) begin
      write_reg(RegRatio, 32'(marks[i]));
      p = random_pair();
      p.f_hi  = '0;
      p.s_mid = '0;
      send_pixel(p);
    end
  endtask

  // tint, tint, pass, then a cleared accumulator landing exactly on the limit
  task automatic test_dither_threshold();
    pix_pair_t p;
    write_reg(RegRatio, 32'(RatioMax));
    write_reg(RegMode, 32'(ModeDither2));
    p = random_pair();
    p.s_hi = '0;
    p.frame_start = 1'b1;
    send_pixel(p);
    p = random_pair();
    p.s_hi = '0;
    p.frame_start = 1'b0;
    send_pixel(p);
    p = random_pair();
    p.s_hi = FullByte;
    p.frame_start = 1'b0;
    send_pixel(p);
    p = random_pair();
    p.s_hi = 8'(int'(FullByte) - int'(DitherLimit));
    p.frame_start = 1'b1;
    send_pixel(p);
  endtask

  task automatic test_random_mixes();
    logic [RatioW-1:0] r;
    logic [ModeW-1:0]  m;
    for (int seg = 0; seg < Segments; seg++) begin
      case ($urandom_range(5))
        0: r = '0;
        1: r = RatioMax;
        2: r = '1;
        3: r = RatioHalf;
        default: r = RatioW'($urandom_range(2**RatioW - 1));
      endcase
      if ($urandom_range(2) == 0) m = $urandom_range(1) ? ModeDither1 : ModeDither2;
      else m = ModeW'($urandom_range(2**ModeW - 1));
      write_reg(RegRatio, 32'(r));
      write_reg(RegMode, 32'(m));
      repeat (SegBeats) send_pixel(random_pair());
    end
  endtask

  initial begin
    send_idle_pct = 10;
    recv_idle_pct = 79;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_mode_sweep();
    test_ratio_marks();
    test_dither_threshold();
    test_random_mixes();

    send_idle_pct = 79;
    recv_idle_pct = 10;
    test_random_mixes();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mixes();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("checked %0d pixel beats across %0d register writes, all 16 mode codes",
             n_pixels, n_writes);
    $display("ratio extremes incl. saturation, %0d dither tint steps, three stall profiles",
             n_tinted);
    if (n_errors == 0) begin
      $display("two_image_false_colour_overlay_mixer_tb passed");
    end else begin
      $display("two_image_false_colour_overlay_mixer_tb failed");
    end
    $finish;
  end

endmodule
